FILE: rtl/bounded_run_coloring_count_core_macros.svh
`ifndef BOUNDED_RUN_COLORING_COUNT_CORE_MACROS_SVH
`define BOUNDED_RUN_COLORING_COUNT_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define BRCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brcc check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define BRCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brcc check failed");

`endif

FILE: rtl/brcc_pkg.sv
`timescale 1ns / 1ps

package brcc_pkg;

    localparam int MAX_LEN = 1024;
    localparam int DEPTH   = MAX_LEN + 1;
    localparam int NUM_COL = 3;
    localparam int LEN_W   = 11;
    localparam int CNT_W   = 30;
    localparam int POS_W   = $clog2(MAX_LEN + 1);
    localparam int CMP_W   = (POS_W > LEN_W) ? POS_W : LEN_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] CNT_MOD = 30'd1000000007;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RED_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_LIMIT  = 2'd2;

    typedef logic [NUM_COL-1:0][LEN_W-1:0] limit_arr_t;
    typedef logic [NUM_COL-1:0][CNT_W-1:0] cnt_arr_t;

    typedef struct packed {
        logic start;
        logic init;
        logic win;
        logic tot;
        logic upd;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic zero_len;
    } status_t;

    // (a - b) mod M, both below M
    function automatic logic [CNT_W-1:0] mod_sub(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (d[CNT_W])
            d = d + {1'b0, CNT_MOD};
        return d[CNT_W-1:0];
    endfunction

    // (a + b + c) mod M, all below M
    function automatic logic [CNT_W-1:0] mod_sum3(input logic [CNT_W-1:0] a,
                                                  input logic [CNT_W-1:0] b,
                                                  input logic [CNT_W-1:0] c);
        logic [CNT_W+1:0] s;
        logic [CNT_W+1:0] m1;
        logic [CNT_W+1:0] m2;
        m1 = {2'b00, CNT_MOD};
        m2 = {1'b0, CNT_MOD, 1'b0};
        s = {2'b00, a} + {2'b00, b} + {2'b00, c};
        if (s >= m2)
            s = s - m2;
        else if (s >= m1)
            s = s - m1;
        return s[CNT_W-1:0];
    endfunction

    // (p + t - w) mod M, all below M
    function automatic logic [CNT_W-1:0] mod_add_sub(input logic [CNT_W-1:0] p,
                                                     input logic [CNT_W-1:0] t,
                                                     input logic [CNT_W-1:0] w);
        logic [CNT_W+1:0] x;
        logic [CNT_W+1:0] m1;
        m1 = {2'b00, CNT_MOD};
        x = {2'b00, p} + {2'b00, t} - {2'b00, w};
        if (x[CNT_W+1])
            x = x + m1;
        else if (x >= m1)
            x = x - m1;
        return x[CNT_W-1:0];
    endfunction

endpackage

FILE: rtl/bounded_run_coloring_count_core.sv
`timescale 1ns / 1ps
// one word in, one count out; n = sequence length clamped to 1024
// in_stall holds off a new word until the read, window, total, update loop over
// the prefix memories has covered every position and the count has been loaded out
// reset: all run limits return to 1, control goes idle, prefix memories keep their contents

module bounded_run_coloring_count_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [brcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [brcc_pkg::LEN_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [brcc_pkg::LEN_W-1:0]         sequence_length,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [brcc_pkg::CNT_W-1:0]         sequence_count
);
    import brcc_pkg::*;

    limit_arr_t limit_reg;
    limit_arr_t limit_next;
    cmd_t       cmd;
    status_t    status;

    always_comb
    begin
        limit_next = limit_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_RED_LIMIT:   limit_next[0] = cfg_data;
                REG_GREEN_LIMIT: limit_next[1] = cfg_data;
                REG_BLUE_LIMIT:  limit_next[2] = cfg_data;
                default:         limit_next = limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_COL; c++)
                limit_reg[c] <= LEN_W'(1);
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    brcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    brcc_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .seq_len (sequence_length),
        .limits  (limit_reg),
        .status  (status),
        .count   (sequence_count)
    );

endmodule

FILE: rtl/brcc_ctrl.sv
`timescale 1ns / 1ps

module brcc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  brcc_pkg::status_t status,
    output brcc_pkg::cmd_t    cmd
);
    import brcc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INIT = 6'b000010,
        S_WIN  = 6'b000100,
        S_TOT  = 6'b001000,
        S_UPD  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = status.zero_len ? S_DONE : S_WIN;
            end
            S_WIN:
            begin
                cmd.win    = 1'b1;
                state_next = S_TOT;
            end
            S_TOT:
            begin
                cmd.tot    = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = status.last ? S_DONE : S_WIN;
            end
            S_DONE:
            begin
                // wait until the output register is free
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (cmd.load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/brcc_dpath.sv
`timescale 1ns / 1ps

module brcc_dpath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  brcc_pkg::cmd_t               cmd,
    input  logic [brcc_pkg::LEN_W-1:0]   seq_len,
    input  brcc_pkg::limit_arr_t         limits,
    output brcc_pkg::status_t            status,
    output logic [brcc_pkg::CNT_W-1:0]   count
);
    import brcc_pkg::*;

    localparam logic [CMP_W-1:0] MAX_LEN_C = CMP_W'(MAX_LEN);

    logic [POS_W-1:0] n_reg;
    logic [POS_W-1:0] n_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] np;
    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] np_ext;

    cnt_arr_t         pre_reg;
    cnt_arr_t         rd_reg;
    cnt_arr_t         w_reg;
    cnt_arr_t         w_next;
    cnt_arr_t         pre_new;
    logic [CNT_W-1:0] t_reg;
    logic [CNT_W-1:0] t_next;
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] count_reg;

    assign len_ext = CMP_W'(seq_len);
    assign n_next  = (len_ext > MAX_LEN_C) ? MAX_LEN_C[POS_W-1:0] : len_ext[POS_W-1:0];

    // position whose memory reads are issued this cycle
    assign np       = cmd.init ? POS_W'(1) : pos_reg + POS_W'(1);
    assign pos_next = np;
    assign pos_ext  = CMP_W'(pos_reg);
    assign np_ext   = CMP_W'(np);

    assign t_next = mod_sum3(w_reg[0], w_reg[1], w_reg[2]);

    for (genvar c = 0; c < NUM_COL; c++)
    begin : g_col
        logic [CNT_W-1:0] mem [DEPTH];
        logic [CMP_W-1:0] lim_ext;
        logic [CMP_W-1:0] lo_idx;
        logic [POS_W-1:0] raddr;
        logic [POS_W-1:0] waddr;
        logic [CNT_W-1:0] wdata;

        assign lim_ext = CMP_W'(limits[c]);
        // window start below the next position: read the prefix just before it
        assign lo_idx  = np_ext - lim_ext - CMP_W'(1);
        assign raddr   = ((lim_ext != '0) && (lim_ext < np_ext)) ? lo_idx[POS_W-1:0] : '0;
        assign waddr   = cmd.init ? '0 : pos_reg;
        assign wdata   = cmd.init ? CNT_W'(1) : pre_new[c];

        assign pre_new[c] = mod_add_sub(pre_reg[c], t_reg, w_reg[c]);

        always_comb
        begin
            if (lim_ext == '0)
                w_next[c] = '0;
            else if (lim_ext < pos_ext)
                w_next[c] = mod_sub(pre_reg[c], rd_reg[c]);
            else
                w_next[c] = pre_reg[c];
        end

        always_ff @(posedge clk)
        begin
            if (cmd.init || cmd.upd)
            begin
                mem[waddr] <= wdata;
                rd_reg[c]  <= mem[raddr];
            end
        end

        always_ff @(posedge clk)
        begin
            if (cmd.init)
                pre_reg[c] <= CNT_W'(1);
            else if (cmd.upd)
                pre_reg[c] <= pre_new[c];
            if (cmd.win)
                w_reg[c] <= w_next[c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tot)
            t_reg <= t_next;
        if (cmd.init)
            total_reg <= CNT_W'(1);
        else if (cmd.upd)
            total_reg <= t_reg;
        if (cmd.load_out)
            count_reg <= total_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg   <= '0;
            pos_reg <= '0;
        end
        else
        begin
            if (cmd.start)
                n_reg <= n_next;
            if (cmd.init || cmd.upd)
                pos_reg <= pos_next;
        end
    end

    assign status.last     = (pos_reg == n_reg);
    assign status.zero_len = (n_reg == '0);
    assign count           = count_reg;

endmodule

FILE: rtl/brcc_checker.sv
`timescale 1ns / 1ps
`include "bounded_run_coloring_count_core_macros.svh"

module brcc_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               cfg_we,
    input logic [brcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [brcc_pkg::LEN_W-1:0]         cfg_data,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic [brcc_pkg::LEN_W-1:0]         sequence_length,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic [brcc_pkg::CNT_W-1:0]         sequence_count
);
    import brcc_pkg::*;

    logic cfg_seen;
    logic in_seen;

    assign cfg_seen = cfg_we && (cfg_index != '0 || cfg_data != '0);
    assign in_seen  = in_valid && (sequence_length != '0 || !in_stall);

    // a taken word makes the block busy on the next cycle
    `BRCC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    // a stalled result keeps its value
    `BRCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sequence_count))
    // every count is reduced
    `BRCC_ASSERT_NOW(a_count_reduced, out_valid || cfg_seen || in_seen,
                     !out_valid || sequence_count < CNT_MOD)
    // a fresh result only follows a busy period
    `BRCC_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(in_stall))

endmodule

bind bounded_run_coloring_count_core brcc_checker u_brcc_checker (.*);

FILE: verif/bounded_run_coloring_count_checker.sv
`timescale 1ns / 1ps

module bounded_run_coloring_count_checker
    import brcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [LEN_W-1:0]     sequence_length,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [CNT_W-1:0]     sequence_count,
    output int                   mismatches,
    output int                   outstanding
);

    localparam longint unsigned COUNT_MOD = longint'(CNT_MOD);

    // per colour: run limit, and running sum of counts not ending in that colour
    logic [LEN_W-1:0]  run_limit [NUM_COL];
    longint unsigned   not_ending_sum [NUM_COL][0:MAX_LEN];
    logic [CNT_W-1:0]  expected_counts [$];

    function automatic logic [CNT_W-1:0] count_colourings(input logic [LEN_W-1:0] req_len);
        int              n;
        int              span;
        longint unsigned lo;
        longint unsigned total;
        longint unsigned run_ends [NUM_COL];
        n = (req_len > MAX_LEN) ? MAX_LEN : int'(req_len);
        total = 1;
        for (int c = 0; c < NUM_COL; c++)
            not_ending_sum[c][0] = 1;
        for (int i = 1; i <= n; i++)
        begin
            for (int c = 0; c < NUM_COL; c++)
            begin
                // window of the last span positions, clamped at position 0
                span = (run_limit[c] < i) ? int'(run_limit[c]) : i;
                lo = (span < i) ? not_ending_sum[c][i-span-1] : 0;
                run_ends[c] = (not_ending_sum[c][i-1] + COUNT_MOD - lo) % COUNT_MOD;
            end
            total = (run_ends[0] + run_ends[1] + run_ends[2]) % COUNT_MOD;
            for (int c = 0; c < NUM_COL; c++)
                not_ending_sum[c][i] = (not_ending_sum[c][i-1]
                                        + (total + COUNT_MOD - run_ends[c]) % COUNT_MOD)
                                       % COUNT_MOD;
        end
        return total[CNT_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int               pushed;
        int               popped;
        int               new_fails;
        logic [CNT_W-1:0] want;
        if (!rst_n)
        begin
            run_limit = '{default: LEN_W'(1)};
            expected_counts.delete();
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            pushed = 0;
            popped = 0;
            new_fails = 0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RED_LIMIT:   run_limit[0] = cfg_data;
                    REG_GREEN_LIMIT: run_limit[1] = cfg_data;
                    REG_BLUE_LIMIT:  run_limit[2] = cfg_data;
                    default: ;
                endcase
            end
            // output first, so a word cannot match an input taken at the same edge
            if (out_valid && !out_stall)
            begin
                if (expected_counts.size() == 0)
                begin
                    new_fails = 1;
                    if (mismatches < 10)
                        $display("[%0t] unexpected output word: count %0d",
                                 $realtime, sequence_count);
                end
                else
                begin
                    want = expected_counts.pop_front();
                    popped = 1;
                    if (sequence_count !== want)
                    begin
                        new_fails = 1;
                        if (mismatches < 10)
                            $display("[%0t] sequence_count mismatch: expected %0d, got %0d",
                                     $realtime, want, sequence_count);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_counts.push_back(count_colourings(sequence_length));
                pushed = 1;
            end
            outstanding <= outstanding + pushed - popped;
            mismatches <= mismatches + new_fails;
        end
    end

endmodule

FILE: verif/tb_bounded_run_coloring_count_core.sv
`timescale 1ns / 1ps

module tb_bounded_run_coloring_count_core;
    import brcc_pkg::*;

    // index with no register behind it, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int IDLE_LIMIT      = 20000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 33;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEN_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [LEN_W-1:0]     sequence_length;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [CNT_W-1:0]     sequence_count;
    logic                 steady = 1'b0;
    int                   mismatches;
    int                   outstanding;
    int                   stall_left = 0;
    int                   idle_cycles = 0;

    always #10 clk = ~clk;

    bounded_run_coloring_count_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .sequence_length (sequence_length),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .sequence_count  (sequence_count)
    );

    bounded_run_coloring_count_checker count_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .sequence_length (sequence_length),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .sequence_count  (sequence_count),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    // receiver holds off in bursts of random length, except in the steady phase
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!steady && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 5);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [LEN_W-1:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return LEN_W'($urandom_range(0, 40));
        else if (roll < 92)
            return LEN_W'($urandom_range(0, 1023));
        else if (roll < 96)
            return LEN_W'($urandom_range(1024, 2047));
        else
            return ($urandom_range(0, 1) == 0) ? 11'd0 : 11'd1024;
    endfunction

    function automatic logic [LEN_W-1:0] pick_limit();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            return LEN_W'($urandom_range(0, 3));
        else if (roll < 50)
            return LEN_W'($urandom_range(0, 15));
        else if (roll < 70)
            return LEN_W'($urandom_range(0, 2047));
        else
        begin
            case ($urandom_range(0, 3))
                0:       return 11'd0;
                1:       return 11'd1;
                2:       return 11'd1024;
                default: return 11'd2047;
            endcase
        end
    endfunction

    task automatic write_limits(input logic [LEN_W-1:0] red, input logic [LEN_W-1:0] green,
                                input logic [LEN_W-1:0] blue, input logic [LEN_W-1:0] spare);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_RED_LIMIT;
        cfg_data <= red;
        @(posedge clk);
        cfg_index <= REG_GREEN_LIMIT;
        cfg_data <= green;
        @(posedge clk);
        cfg_index <= REG_BLUE_LIMIT;
        cfg_data <= blue;
        @(posedge clk);
        cfg_index <= REG_SPARE;
        cfg_data <= spare;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_length(input logic [LEN_W-1:0] len);
        in_valid <= 1'b1;
        sequence_length <= len;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // block is idle once every count is back
    task automatic drain();
        in_valid <= 1'b0;
        // let the count of words in flight take in the last accept
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic [LEN_W-1:0] reset_lens [9] = '{0, 1, 2, 3, 5, 1023, 1024, 1025, 2047};
        logic [LEN_W-1:0] zero_lens  [3] = '{0, 1, 7};
        logic [LEN_W-1:0] free_lens  [4] = '{1, 2, 20, 1024};
        logic [LEN_W-1:0] mixed_lens [4] = '{1, 3, 10, 2047};
        logic [LEN_W-1:0] other_lens [4] = '{0, 4, 9, 1000};
        cfg_we <= 1'b0;
        cfg_index <= REG_RED_LIMIT;
        cfg_data <= '0;
        in_valid <= 1'b0;
        sequence_length <= '0;
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // limits as left by reset, then lengths past the build limit
        foreach (reset_lens[k])
            send_length(reset_lens[k]);
        drain();
        // no colour usable at all
        write_limits(11'd0, 11'd0, 11'd0, 11'd0);
        foreach (zero_lens[k])
            send_length(zero_lens[k]);
        drain();
        // runs never bounded
        write_limits(11'd1024, 11'd1024, 11'd1024, 11'd1365);
        foreach (free_lens[k])
            send_length(free_lens[k]);
        drain();
        // limit beyond any length, one colour dropped, spare index gets all ones
        write_limits(11'd2047, 11'd0, 11'd1, 11'd2047);
        foreach (mixed_lens[k])
            send_length(mixed_lens[k]);
        drain();
        write_limits(11'd0, 11'd1024, 11'd2, 11'd682);
        foreach (other_lens[k])
            send_length(other_lens[k]);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            steady <= (p == RANDOM_PHASES - 1);
            write_limits(pick_limit(), pick_limit(), pick_limit(),
                         LEN_W'($urandom_range(0, 2047)));
            repeat (ITEMS_PER_PHASE)
                send_length(pick_length());
            drain();
        end

        repeat (6) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/brcc_pkg.sv
rtl/brcc_ctrl.sv
rtl/brcc_dpath.sv
rtl/bounded_run_coloring_count_core.sv
rtl/brcc_checker.sv
verif/bounded_run_coloring_count_checker.sv
verif/tb_bounded_run_coloring_count_core.sv
